>>> sv/gww_pkg.sv
// Shared types, sizes and helpers for the greedy word wrap block.
// Used by gww_ctrl, gww_dp, gww_outq and greedy_word_wrap; depends on nothing.
package gww_pkg;

    // Line buffer geometry
    localparam int DEPTH = 64;                  // bytes held for one line
    localparam int AW    = $clog2(DEPTH);       // buffer address / fill width
    localparam int LW    = $clog2(DEPTH + 1);   // segment length width (up to DEPTH)

    // Field widths
    localparam int CHAR_W    = 8;
    localparam int LEN_W     = 6;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 8;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_LENGTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NEWLINE_CODE = 1'd1;

    // Reset values and fixed codes
    localparam logic [LEN_W-1:0]  LINE_LEN_RST = 6'd63;
    localparam logic [CHAR_W-1:0] NL_RST       = 8'd10;
    localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'h20;

    // Limits in segment-length width
    localparam logic [LW-1:0] LIM_MAX = LW'(DEPTH - 1);
    localparam logic [LW-1:0] LIM_MIN = LW'(1);
    localparam logic [LW:0]   DEPTH_X = (LW + 1)'(DEPTH);

    // Controller -> datapath / queue commands
    typedef struct packed {
        logic accept;     // take the input request
        logic rd;         // read one buffered byte
        logic xmit;       // send the held break / pass-through byte
        logic load_b;     // switch read pointer to the trailing flush
        logic run_end;    // flag for the byte sent this cycle
        logic text_end;
    } t_cmd;

    // Datapath -> controller status
    typedef struct packed {
        logic plan_any;   // accepted byte produces output
        logic plan_a;     // leading buffer segment is not empty
        logic plan_x;     // a single byte follows the leading segment
        logic cnt_one;    // current segment has one byte left
        logic b_nz;       // trailing flush is not empty
        logic last;       // held request was the final byte of the text
    } t_sts;

    // Request into the output queue (one per send)
    typedef struct packed {
        logic              vld;
        logic              is_mem;
        logic [CHAR_W-1:0] x;
        logic              run_end;
        logic              text_end;
    } t_iss;

    // Circular buffer address: base + off, wrapped at DEPTH (sum stays below 2*DEPTH)
    function automatic logic [AW-1:0] gww_wrap(input logic [AW-1:0] base,
                                               input logic [LW-1:0] off);
        logic [LW:0] sum;
        sum = (LW + 1)'(base) + (LW + 1)'(off);
        if (sum >= DEPTH_X) begin
            sum = sum - DEPTH_X;
        end
        return sum[AW-1:0];
    endfunction

endpackage

>>> sv/gww_ctrl.sv
// Sequencer for the greedy word wrap block: accepts a byte, then walks the
// leading flush, break or pass-through byte and trailing flush. Depends on gww_pkg.
module gww_ctrl
    import gww_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_sts i_sts,
    input  logic i_room,
    output t_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_A,
        S_X,
        S_B
    } t_state;

    t_state r_state;
    t_state n_state;

    // Next state and commands
    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    if (i_sts.plan_a) begin
                        n_state = S_A;
                    end else if (i_sts.plan_x) begin
                        n_state = S_X;
                    end else if (i_sts.plan_any) begin
                        n_state = S_B;
                    end
                end
            end
            S_A: begin
                if (i_room) begin
                    o_cmd.rd = 1'b1;
                    if (i_sts.cnt_one) begin
                        n_state = S_X;
                    end
                end
            end
            S_X: begin
                if (i_room) begin
                    o_cmd.xmit     = 1'b1;
                    o_cmd.run_end  = !i_sts.b_nz;
                    o_cmd.text_end = i_sts.last && !i_sts.b_nz;
                    if (i_sts.b_nz) begin
                        o_cmd.load_b = 1'b1;
                        n_state      = S_B;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_B: begin
                // trailing flush only happens on the final byte
                if (i_room) begin
                    o_cmd.rd       = 1'b1;
                    o_cmd.run_end  = i_sts.cnt_one;
                    o_cmd.text_end = i_sts.cnt_one;
                    if (i_sts.cnt_one) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb o_in_stall = (r_state != S_IDLE);

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

>>> sv/gww_dp.sv
// Datapath of the greedy word wrap block: configuration registers, line
// state, circular line buffer and read pointer. Depends on gww_pkg.
module gww_dp
    import gww_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic [CHAR_W-1:0]    i_in_char,
    input  logic                 i_text_last,
    input  t_cmd                 i_cmd,
    output t_sts                 o_sts,
    output logic [CHAR_W-1:0]    o_x_char,
    output logic [CHAR_W-1:0]    o_rd_data
);

    // Configuration
    logic [LEN_W-1:0]  r_line_len;
    logic [CHAR_W-1:0] r_nl;

    // Line state
    logic [AW-1:0] r_head;
    logic [AW-1:0] r_fill;
    logic [AW-1:0] r_spos;
    logic          r_seen;
    logic          r_overlong;

    // Held request plan
    logic [CHAR_W-1:0] r_x;
    logic              r_last;
    logic [AW-1:0]     r_b_start;
    logic [LW-1:0]     r_b_len;
    logic [AW-1:0]     r_rd_ptr;
    logic [LW-1:0]     r_rd_cnt;

    // Line buffer
    logic [CHAR_W-1:0] r_mem [DEPTH];
    logic [CHAR_W-1:0] r_rd_data;

    // Decode of the incoming byte
    logic              c_is_sp;
    logic              c_is_nl;
    logic              brk;
    logic [LW-1:0]     fill_x;
    logic [LW-1:0]     spos_x;
    logic [LW-1:0]     lim_raw;
    logic [LW-1:0]     lim;
    logic              in_lim;
    logic              can_split;
    logic              cs_fill;
    logic              cs_nlf;
    logic              cs_brk;
    logic              cs_split;
    logic              cs_long;
    logic              x_has;
    logic [CHAR_W-1:0] x_char;
    logic [LW-1:0]     a_len;
    logic [LW-1:0]     b_len;
    logic [LW-1:0]     keep;
    logic [AW-1:0]     new_head;
    logic [AW-1:0]     wr_addr;
    logic              wr_en;

    always_comb begin
        c_is_sp = (i_in_char == SPACE_CODE);
        c_is_nl = (i_in_char == r_nl);
        brk     = c_is_sp || c_is_nl;
        fill_x  = LW'(r_fill);
        spos_x  = LW'(r_spos);

        // effective limit, clamped to 1..DEPTH-1
        lim_raw = LW'(r_line_len);
        if (r_line_len == '0) begin
            lim = LIM_MIN;
        end else if (lim_raw > LIM_MAX) begin
            lim = LIM_MAX;
        end else begin
            lim = lim_raw;
        end
        in_lim    = (fill_x < lim);
        can_split = r_seen && (spos_x < fill_x);

        cs_fill  = !r_overlong && in_lim && !c_is_nl;
        cs_nlf   = !r_overlong && in_lim && c_is_nl;
        cs_brk   = !r_overlong && !in_lim && brk;
        cs_split = !r_overlong && !in_lim && !brk && can_split;
        cs_long  = !r_overlong && !in_lim && !brk && !can_split;

        // single byte after the leading segment: break code or the byte itself
        x_has  = !cs_fill;
        x_char = ((r_overlong || cs_long) && !brk) ? i_in_char : r_nl;

        if (cs_nlf || cs_brk || cs_long) begin
            a_len = fill_x;
        end else if (cs_split) begin
            a_len = spos_x;
        end else begin
            a_len = '0;
        end

        // after a split the tail plus the new byte stay buffered
        keep = fill_x - spos_x;
        if (!i_text_last) begin
            b_len = '0;
        end else if (cs_fill) begin
            b_len = fill_x + LW'(1);
        end else if (cs_split) begin
            b_len = keep;
        end else begin
            b_len = '0;
        end

        new_head = cs_split ? gww_wrap(r_head, spos_x + LW'(1)) : r_head;
        // the new byte lands just past the current line in both buffering cases
        wr_addr  = gww_wrap(r_head, fill_x);
        wr_en    = i_cmd.accept && (cs_fill || cs_split);
    end

    // Status
    always_comb begin
        o_sts.plan_any = x_has || (b_len != '0);
        o_sts.plan_a   = (a_len != '0);
        o_sts.plan_x   = x_has;
        o_sts.cnt_one  = (r_rd_cnt == LW'(1));
        o_sts.b_nz     = (r_b_len != '0);
        o_sts.last     = r_last;
    end

    assign o_x_char  = r_x;
    assign o_rd_data = r_rd_data;

    // Control and line state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_len <= LINE_LEN_RST;
            r_nl       <= NL_RST;
            r_head     <= '0;
            r_fill     <= '0;
            r_spos     <= '0;
            r_seen     <= 1'b0;
            r_overlong <= 1'b0;
            r_last     <= 1'b0;
            r_b_len    <= '0;
            r_rd_cnt   <= '0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_LINE_LENGTH) begin
                    r_line_len <= i_cfg_data[LEN_W-1:0];
                end else if (i_cfg_idx == CFG_NEWLINE_CODE) begin
                    r_nl <= i_cfg_data;
                end
            end

            if (i_cmd.accept) begin
                r_head  <= new_head;
                r_last  <= i_text_last;
                r_b_len <= b_len;
                r_rd_cnt <= x_has ? a_len : b_len;
                if (i_text_last) begin
                    // final byte: everything flushes
                    r_fill     <= '0;
                    r_spos     <= '0;
                    r_seen     <= 1'b0;
                    r_overlong <= 1'b0;
                end else begin
                    if (cs_fill) begin
                        r_fill <= r_fill + AW'(1);
                        if (c_is_sp) begin
                            r_spos <= r_fill;
                            r_seen <= 1'b1;
                        end
                    end else if (cs_split) begin
                        r_fill <= AW'(keep);
                        r_spos <= '0;
                        r_seen <= 1'b0;
                    end else if (cs_nlf || cs_brk || cs_long) begin
                        r_fill <= '0;
                        r_spos <= '0;
                        r_seen <= 1'b0;
                    end
                    r_overlong <= r_overlong ? !brk : cs_long;
                end
            end else if (i_cmd.load_b) begin
                r_rd_cnt <= r_b_len;
            end else if (i_cmd.rd) begin
                r_rd_cnt <= r_rd_cnt - LW'(1);
            end
        end
    end

    // Held request payload and read pointer
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_x       <= x_char;
            r_b_start <= new_head;
            r_rd_ptr  <= r_head;
        end else if (i_cmd.load_b) begin
            r_rd_ptr <= r_b_start;
        end else if (i_cmd.rd) begin
            r_rd_ptr <= gww_wrap(r_rd_ptr, LW'(1));
        end
    end

    // Line buffer: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= i_in_char;
        end
        if (i_cmd.rd) begin
            r_rd_data <= r_mem[r_rd_ptr];
        end
    end

endmodule

>>> sv/gww_outq.sv
// Output side of the greedy word wrap block: one issue stage that joins
// buffer reads with direct bytes, then a two-entry queue. Depends on gww_pkg.
module gww_outq
    import gww_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_iss              i_iss,
    input  logic [CHAR_W-1:0] i_rd_data,
    input  logic              i_out_stall,
    output logic              o_out_valid,
    output logic [CHAR_W-1:0] o_out_char,
    output logic              o_run_end,
    output logic              o_text_end,
    output logic              o_room
);

    // Issue stage (buffer read data arrives in the cycle after the read)
    logic              r_p_vld;
    logic              r_p_is_mem;
    logic [CHAR_W-1:0] r_p_x;
    logic              r_p_run_end;
    logic              r_p_text_end;

    // Queue
    logic [CHAR_W-1:0] r_q_char [2];
    logic              r_q_run  [2];
    logic              r_q_txt  [2];
    logic              r_wp;
    logic              r_rp;
    logic [1:0]        r_cnt;

    logic              push;
    logic              pop;
    logic [CHAR_W-1:0] push_char;
    logic [1:0]        occ;

    always_comb begin
        push      = r_p_vld;
        pop       = (r_cnt != 2'd0) && !i_out_stall;
        push_char = r_p_is_mem ? i_rd_data : r_p_x;
        // entries held plus one in flight, less what leaves this cycle
        occ       = r_cnt + 2'(r_p_vld);
        o_room    = ((occ - 2'(pop)) < 2'd2);
    end

    assign o_out_valid = (r_cnt != 2'd0);
    assign o_out_char  = r_q_char[r_rp];
    assign o_run_end   = r_q_run[r_rp];
    assign o_text_end  = r_q_txt[r_rp];

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_vld <= 1'b0;
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
            r_cnt   <= 2'd0;
        end else begin
            r_p_vld <= i_iss.vld;
            if (push) begin
                r_wp <= !r_wp;
            end
            if (pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        r_p_is_mem   <= i_iss.is_mem;
        r_p_x        <= i_iss.x;
        r_p_run_end  <= i_iss.run_end;
        r_p_text_end <= i_iss.text_end;
        if (push) begin
            r_q_char[r_wp] <= push_char;
            r_q_run[r_wp]  <= r_p_run_end;
            r_q_txt[r_wp]  <= r_p_text_end;
        end
    end

endmodule

>>> sv/greedy_word_wrap.sv
// Top level of the greedy word wrap block: joins controller, datapath and
// output queue. Depends on gww_pkg, gww_ctrl, gww_dp and gww_outq.
//
//   channel  direction  handshake                 payload
//   input    in         i_in_valid / o_in_stall   i_in_char, i_text_last
//   output   out        o_out_valid / i_out_stall o_out_char, o_run_end, o_text_end
//   config   in         i_cfg_we (no wait)        i_cfg_idx, i_cfg_data
//
// The line buffer has one read port, so a flush moves one byte per cycle while
// the output queue has room. Each result is registered in the issue stage, then
// in the queue, before it reaches o_out_*. Synchronous active-low reset; the
// line buffer is not cleared. Output stalls hold the sequencer through a
// two-entry queue; new input is taken again once the last result of a request
// has been sent to the queue.
module greedy_word_wrap
    import gww_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [CHAR_W-1:0]    i_in_char,
    input  logic                 i_text_last,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [CHAR_W-1:0]    o_out_char,
    output logic                 o_run_end,
    output logic                 o_text_end,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    t_cmd              cmd;
    t_sts              sts;
    t_iss              iss;
    logic              room;
    logic [CHAR_W-1:0] x_char;
    logic [CHAR_W-1:0] rd_data;

    gww_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .i_room     (room),
        .o_cmd      (cmd)
    );

    gww_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_char   (i_in_char),
        .i_text_last (i_text_last),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_x_char    (x_char),
        .o_rd_data   (rd_data)
    );

    // Send request into the output queue
    always_comb begin
        iss.vld      = cmd.rd || cmd.xmit;
        iss.is_mem   = cmd.rd;
        iss.x        = x_char;
        iss.run_end  = cmd.run_end;
        iss.text_end = cmd.text_end;
    end

    gww_outq u_outq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_iss       (iss),
        .i_rd_data   (rd_data),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_char  (o_out_char),
        .o_run_end   (o_run_end),
        .o_text_end  (o_text_end),
        .o_room      (room)
    );

endmodule
